// ===== hdl/bre_pkg.sv =====
// ----------------------------------------------------------------------------
// Button report change events package
// Shared constants, event codes and decode helpers for the change-event block.
// ----------------------------------------------------------------------------
`default_nettype none

package bre_pkg;

    // Accepted report framing.
    localparam logic [7:0] HEADER_OK = 8'ha1;
    localparam logic [7:0] REPORT_OK = 8'h30;

    // Event kinds.
    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_AXIS = 2'd1;
    localparam logic [1:0] KIND_SYNC = 2'd2;

    // Event slots in emission order: seven keys, two axes, then sync.
    localparam int NUM_KEYS  = 7;
    localparam int NUM_AXES  = 2;
    localparam int NUM_SLOTS = NUM_KEYS + NUM_AXES + 1;
    localparam int SYNC_SLOT = NUM_SLOTS - 1;

    typedef logic [NUM_SLOTS-1:0] slot_mask_t;
    typedef logic [3:0]           slot_idx_t;

    localparam logic [15:0] HOME_MASK = 16'h0080;

    localparam logic [15:0] KEY_MASK [NUM_KEYS] = '{
        16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010, 16'h0080, 16'h1000
    };
    localparam logic [15:0] AXIS_LO [NUM_AXES] = '{16'h0800, 16'h0200};
    localparam logic [15:0] AXIS_HI [NUM_AXES] = '{16'h0400, 16'h0100};

    // Direction pair decode: low bit alone gives -1, high bit alone +1.
    function automatic logic signed [1:0] axis_value(input logic [15:0] w, input int k);
        logic [15:0] m;
        begin
            m = w & (AXIS_LO[k] | AXIS_HI[k]);
            if (m == AXIS_LO[k])
            begin
                axis_value = -2'sd1;
            end
            else if (m == AXIS_HI[k])
            begin
                axis_value = 2'sd1;
            end
            else
            begin
                axis_value = 2'sd0;
            end
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bre_rpt_if.sv =====
// ----------------------------------------------------------------------------
// Report channel
// Carries one controller report per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bre_rpt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  header_byte;
    logic [7:0]  report_id;
    logic [15:0] button_word;
    logic        short_read;

    modport source (output valid, header_byte, report_id, button_word, short_read,
                    input ready);
    modport sink   (input valid, header_byte, report_id, button_word, short_read,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/bre_evt_if.sv =====
// ----------------------------------------------------------------------------
// Event channel
// Carries one change event per item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bre_evt_if;
    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [3:0]        control_index;
    logic signed [1:0] event_value;
    logic              last_of_run;
    logic              session_stop;

    modport source (output valid, event_kind, control_index, event_value, last_of_run,
                    session_stop, input ready);
    modport sink   (input valid, event_kind, control_index, event_value, last_of_run,
                    session_stop, output ready);
endinterface

`default_nettype wire

// ===== hdl/button_report_change_events_core.sv =====
// ----------------------------------------------------------------------------
// Button report change events core
// Turns controller reports into a serial run of key, axis and sync events.
// ----------------------------------------------------------------------------
// The first event of a report passes the input register, the pending mask
// and the output register before it is offered. Throughput: one event per
// cycle while the event channel is ready; a report holds the event emitter
// until all its events are handed on. Reset clears the previous button word
// and the stopped flag, and empties every stage.
`default_nettype none

module button_report_change_events_core
    import bre_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    bre_rpt_if.sink    rpt,
    bre_evt_if.source  evt
);

    // The block is three stages. An input register holds one report. When
    // the emitter is free (or frees up this cycle) the report is decoded in
    // one pass against the stored previous word, and the decode becomes a
    // mask of pending event slots. The emitter hands the lowest pending slot
    // to the output register each cycle the output register can take it.
    // All state updates happen at the moment a report is decoded, so the
    // next report always sees the state its predecessor left behind.

    // Input register.
    logic        iv_reg;
    logic [7:0]  ihdr_reg;
    logic [7:0]  iid_reg;
    logic [15:0] iword_reg;
    logic        ishort_reg;

    // Architectural state.
    logic [15:0] prev_reg, prev_next;
    logic        stopped_reg, stopped_next;

    // Emitter.
    slot_mask_t  pend_reg, pend_next;
    logic [15:0] ecur_reg;
    logic        ehome_reg;

    // Output register.
    logic              ov_reg, ov_next;
    logic [1:0]        okind_reg;
    logic [3:0]        oidx_reg;
    logic signed [1:0] oval_reg;
    logic              olast_reg;
    logic              ostop_reg;

    // Emitter control.
    slot_mask_t low_bit;
    slot_mask_t pend_after;
    slot_idx_t  low_idx;
    logic       advance;
    logic       load_emit;

    // Decode of the report in the input register.
    slot_mask_t new_mask;
    logic       new_home;

    // Event built from the lowest pending slot.
    logic [1:0]        ev_kind;
    logic [3:0]        ev_idx;
    logic signed [1:0] ev_val;
    logic              ev_last;
    logic              ev_stop;

    always_comb
    begin
        low_bit    = pend_reg & (~pend_reg + slot_mask_t'(1));
        advance    = (pend_reg != '0) && (!ov_reg || evt.ready);
        pend_after = advance ? (pend_reg & ~low_bit) : pend_reg;
        load_emit  = iv_reg && (pend_after == '0);
        low_idx    = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = slot_idx_t'(i);
            end
        end
    end

    // A new report can enter whenever the input register is empty or is
    // being moved into the emitter in this cycle.
    assign rpt.ready = !iv_reg || load_emit;

    // Single-pass decode of the held report.
    always_comb
    begin
        new_mask     = '0;
        new_home     = (iword_reg & HOME_MASK) != '0;
        prev_next    = prev_reg;
        stopped_next = stopped_reg;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            new_mask[k] = ((iword_reg & KEY_MASK[k]) != '0) !=
                          ((prev_reg & KEY_MASK[k]) != '0);
        end
        for (int k = 0; k < NUM_AXES; k++)
        begin
            new_mask[NUM_KEYS + k] = axis_value(iword_reg, k) != axis_value(prev_reg, k);
        end
        // A sync closes any non-empty run, except when home ends the session.
        new_mask[SYNC_SLOT] = (new_mask[SYNC_SLOT-1:0] != '0) && !new_home;

        if (stopped_reg)
        begin
            new_mask = '0;
        end
        else if (ishort_reg)
        begin
            new_mask     = '0;
            stopped_next = 1'b1;
        end
        else if (ihdr_reg != HEADER_OK || iid_reg != REPORT_OK || iword_reg == prev_reg)
        begin
            new_mask = '0;
        end
        else if (new_home)
        begin
            // Home press: events go out, the previous word stays, block stops.
            stopped_next = 1'b1;
        end
        else
        begin
            prev_next = iword_reg;
        end
    end

    // Event fields for the lowest pending slot.
    always_comb
    begin
        ev_last = (pend_reg & ~low_bit) == '0;
        ev_stop = ev_last && ehome_reg;
        ev_idx  = '0;
        ev_val  = 2'sd0;
        if (low_idx < slot_idx_t'(NUM_KEYS))
        begin
            ev_kind = KIND_KEY;
            ev_idx  = low_idx;
            ev_val  = ((ecur_reg & KEY_MASK[low_idx[2:0]]) != '0) ? 2'sd1 : 2'sd0;
        end
        else if (low_idx < slot_idx_t'(SYNC_SLOT))
        begin
            ev_kind = KIND_AXIS;
            ev_idx  = low_idx;
            ev_val  = axis_value(ecur_reg, int'(low_idx) - NUM_KEYS);
        end
        else
        begin
            ev_kind = KIND_SYNC;
        end
    end

    always_comb
    begin
        pend_next = load_emit ? new_mask : pend_after;
        if (advance)
        begin
            ov_next = 1'b1;
        end
        else if (evt.ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg      <= 1'b0;
            pend_reg    <= '0;
            ov_reg      <= 1'b0;
            prev_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            if (rpt.ready)
            begin
                iv_reg <= rpt.valid;
            end
            pend_reg <= pend_next;
            ov_reg   <= ov_next;
            if (load_emit)
            begin
                prev_reg    <= prev_next;
                stopped_reg <= stopped_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (rpt.valid && rpt.ready)
        begin
            ihdr_reg   <= rpt.header_byte;
            iid_reg    <= rpt.report_id;
            iword_reg  <= rpt.button_word;
            ishort_reg <= rpt.short_read;
        end
        if (load_emit)
        begin
            ecur_reg  <= iword_reg;
            ehome_reg <= new_home;
        end
        if (advance)
        begin
            okind_reg <= ev_kind;
            oidx_reg  <= ev_idx;
            oval_reg  <= ev_val;
            olast_reg <= ev_last;
            ostop_reg <= ev_stop;
        end
    end

    assign evt.valid         = ov_reg;
    assign evt.event_kind    = okind_reg;
    assign evt.control_index = oidx_reg;
    assign evt.event_value   = oval_reg;
    assign evt.last_of_run   = olast_reg;
    assign evt.session_stop  = ostop_reg;

    // A session stop only ever marks the final event of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.session_stop |-> evt.last_of_run)
        else $error("session_stop on an event that is not last of its run");

    // Sync always closes a run and never appears in a home-terminated run.
    assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && evt.event_kind == KIND_SYNC |-> evt.last_of_run && !evt.session_stop)
        else $error("sync event is not a plain end of run");

    // Once stopped, the block stays stopped until reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped flag cleared without reset");

    // A report is decoded only when the emitter has nothing left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_emit |-> pend_after == '0)
        else $error("report decoded while events were still pending");

endmodule

`default_nettype wire

// ===== bench/button_report_change_events_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button report change events core testbench
// Sends controller reports through the report channel and checks every event
// against a predictor of the change-event logic. It covers report framing,
// key and axis changes, unmapped bits, output stalls and the home-button stop.
// ----------------------------------------------------------------------------
`default_nettype none

module button_report_change_events_core_test;
    import bre_pkg::*;

    // One report as it travels on the report channel.
    typedef struct packed {
        logic [7:0]  header_byte;
        logic [7:0]  report_id;
        logic [15:0] button_word;
        logic        short_read;
    } report_t;

    // One change event as it travels on the event channel.
    typedef struct packed {
        logic [1:0]        event_kind;
        logic [3:0]        control_index;
        logic signed [1:0] event_value;
        logic              last_of_run;
        logic              session_stop;
    } change_event_t;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTED  = 10;

    // Button bits that take part in neither a key nor a direction pair.
    localparam logic [15:0] UNMAPPED_BITS = 16'he060;
    // Mapped bits other than home; flipping them never ends the session.
    localparam logic [15:0] SAFE_MAPPED_BITS = 16'h1f1f;

    logic clk = 1'b0;
    logic rst_n;

    bre_rpt_if rpt_ch();
    bre_evt_if evt_ch();

    button_report_change_events_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rpt   (rpt_ch),
        .evt   (evt_ch)
    );

    always #5 clk = ~clk;

    // Predictor state: the last button word that the block stored, and whether
    // the session has ended.
    logic [15:0]   last_buttons;
    bit            session_over;
    change_event_t pending_events[$];

    // Idle rates in percent of cycles for the sender and the receiver.
    int src_idle_pct;
    int sink_idle_pct;

    // A test asks for a long receiver hold-off here; the receiver process
    // takes the request over and counts the hold-off down itself.
    int hold_request;
    int hold_left;

    int cycle_count;
    int fail_count;
    int mismatch_count;
    int reports_sent;
    int events_seen;
    int key_events;
    int axis_events;
    int sync_events;
    int input_stall_cycles;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Value of a direction pair: the low bit alone points negative, the high
    // bit alone points positive, neither or both means centered.
    function automatic logic signed [1:0] pair_direction(input logic [15:0] word,
                                                         input logic [15:0] neg_bit,
                                                         input logic [15:0] pos_bit);
        logic [15:0] seen;
        begin
            seen = word & (neg_bit | pos_bit);
            if (seen == neg_bit)
            begin
                return -2'sd1;
            end
            else if (seen == pos_bit)
            begin
                return 2'sd1;
            end
            return 2'sd0;
        end
    endfunction

    // Works out the events that one accepted report causes and queues them.
    function automatic void predict_change_events(input report_t rep);
        change_event_t run[10];
        int            count;
        logic          now_down;
        logic          was_down;
        logic signed [1:0] dir_now;
        logic signed [1:0] dir_was;
        begin
            count = 0;
            if (session_over)
            begin
                return;
            end
            // A short read ends the session before the framing is even looked at.
            if (rep.short_read)
            begin
                session_over = 1'b1;
                return;
            end
            if (rep.header_byte != HEADER_OK || rep.report_id != REPORT_OK)
            begin
                return;
            end
            if (rep.button_word == last_buttons)
            begin
                return;
            end
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                now_down = |(rep.button_word & KEY_MASK[k]);
                was_down = |(last_buttons & KEY_MASK[k]);
                if (now_down != was_down)
                begin
                    run[count] = '{KIND_KEY, 4'(k), {1'b0, now_down}, 1'b0, 1'b0};
                    count++;
                end
            end
            for (int k = 0; k < NUM_AXES; k++)
            begin
                dir_now = pair_direction(rep.button_word, AXIS_LO[k], AXIS_HI[k]);
                dir_was = pair_direction(last_buttons, AXIS_LO[k], AXIS_HI[k]);
                if (dir_now != dir_was)
                begin
                    run[count] = '{KIND_AXIS, 4'(NUM_KEYS + k), dir_now, 1'b0, 1'b0};
                    count++;
                end
            end
            if (|(rep.button_word & HOME_MASK))
            begin
                // Home closes the run without sync and leaves the stored word alone.
                session_over = 1'b1;
                if (count > 0)
                begin
                    run[count-1].last_of_run  = 1'b1;
                    run[count-1].session_stop = 1'b1;
                end
            end
            else
            begin
                if (count > 0)
                begin
                    run[count] = '{KIND_SYNC, 4'd0, 2'sd0, 1'b1, 1'b0};
                    count++;
                end
                last_buttons = rep.button_word;
            end
            for (int i = 0; i < count; i++)
            begin
                pending_events.push_back(run[i]);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Report sender
    // ------------------------------------------------------------------------

    // Offers one report, idling first at the current sender rate, and returns
    // right after the edge at which the report was accepted.
    task automatic send_report(input report_t rep);
        begin
            while ($urandom_range(99) < src_idle_pct)
            begin
                rpt_ch.valid <= 1'b0;
                @(posedge clk);
            end
            rpt_ch.valid       <= 1'b1;
            rpt_ch.header_byte <= rep.header_byte;
            rpt_ch.report_id   <= rep.report_id;
            rpt_ch.button_word <= rep.button_word;
            rpt_ch.short_read  <= rep.short_read;
            @(posedge clk);
            while (!rpt_ch.ready)
            begin
                input_stall_cycles++;
                @(posedge clk);
            end
            reports_sent++;
            predict_change_events(rep);
        end
    endtask

    task automatic send_good(input logic [15:0] word);
        begin
            send_report('{HEADER_OK, REPORT_OK, word, 1'b0});
        end
    endtask

    // Drops valid and waits until every expected event has come out, then
    // gives reports that cause no event time to leave the block.
    task automatic wait_idle();
        begin
            rpt_ch.valid <= 1'b0;
            while (pending_events.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Event receiver and checker
    // ------------------------------------------------------------------------

    // Ready follows the receiver idle rate, except during a requested hold-off.
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            evt_ch.ready <= 1'b0;
        end
        else
        begin
            evt_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Every accepted event is compared with the oldest expectation.
    always @(posedge clk)
    begin
        change_event_t got;
        change_event_t want;
        if (rst_n && evt_ch.valid && evt_ch.ready)
        begin
            got = '{evt_ch.event_kind, evt_ch.control_index, evt_ch.event_value,
                    evt_ch.last_of_run, evt_ch.session_stop};
            events_seen++;
            case (got.event_kind)
                KIND_KEY:  key_events++;
                KIND_AXIS: axis_events++;
                KIND_SYNC: sync_events++;
                default: ;
            endcase
            if (pending_events.size() == 0)
            begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                begin
                    $display("ERROR: unexpected event kind=%0d index=%0d value=%0d",
                             got.event_kind, got.control_index, got.event_value);
                    $display("  last=%0b stop=%0b", got.last_of_run, got.session_stop);
                end
            end
            else
            begin
                want = pending_events.pop_front();
                if (got.event_kind != want.event_kind
                    || got.control_index != want.control_index
                    || got.event_value != want.event_value
                    || got.last_of_run != want.last_of_run
                    || got.session_stop != want.session_stop)
                begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                    begin
                        $display("ERROR: event mismatch at cycle %0d", cycle_count);
                        $display("  expected kind=%0d index=%0d value=%0d last=%0b stop=%0b",
                                 want.event_kind, want.control_index, want.event_value,
                                 want.last_of_run, want.session_stop);
                        $display("  actual   kind=%0d index=%0d value=%0d last=%0b stop=%0b",
                                 got.event_kind, got.control_index, got.event_value,
                                 got.last_of_run, got.session_stop);
                    end
                end
            end
        end
    end

    // A hung handshake must not stall the run forever.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ERROR: run exceeded %0d cycles", CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reports with a wrong header byte or report id must vanish without a
    // trace, even when their word would change keys or press home.
    task automatic test_framing();
        begin
            send_report('{8'h00, REPORT_OK, 16'h0001, 1'b0});
            send_report('{8'hff, REPORT_OK, 16'h0001, 1'b0});
            send_report('{HEADER_OK, 8'h00, 16'h0001, 1'b0});
            send_report('{HEADER_OK, 8'hff, 16'h0001, 1'b0});
            send_report('{HEADER_OK, 8'h31, 16'hffff, 1'b0});
            // Same word as after reset: no events.
            send_good(16'h0000);
        end
    endtask

    // All keys but home at once, then releases and a swap of two keys.
    task automatic test_keys();
        begin
            send_good(16'h101f);
            send_good(16'h0000);
            send_good(16'h0008);
            send_good(16'h0004);
        end
    endtask

    // Both direction pairs through negative, positive and both-bits-set, and
    // a word change in axis bits that leaves both axes centered.
    task automatic test_axes();
        begin
            send_good(16'h0a00);
            send_good(16'h0500);
            send_good(16'h0f00);
            send_good(16'h0000);
            send_good(16'h0800);
            send_good(16'h0c00);
        end
    endtask

    // A change in unmapped bits alone gives nothing, yet the stored word
    // still moves on, which the next report shows.
    task automatic test_unmapped_bits();
        begin
            send_good(16'h0000);
            send_good(UNMAPPED_BITS);
            send_good(16'hff7f);
            send_good(16'h0000);
        end
    endtask

    // Random reports: mostly well formed with content that exercises small
    // and large changes, plus some noise with broken framing. Only reports
    // that pass the framing count toward the total.
    task automatic test_random_reports(input int good_reports);
        report_t rep;
        int      framed;
        int      pick;
        begin
            framed = 0;
            while (framed < good_reports)
            begin
                pick = $urandom_range(99);
                rep  = '{HEADER_OK, REPORT_OK, 16'($urandom), 1'b0};
                if (pick < 12)
                begin
                    // Noise: any word, home included, with bad framing.
                    rep.header_byte = 8'($urandom_range(255));
                    rep.report_id   = 8'($urandom_range(255));
                    if (rep.header_byte == HEADER_OK && rep.report_id == REPORT_OK)
                    begin
                        rep.report_id = rep.report_id ^ 8'($urandom_range(255, 1));
                    end
                end
                else
                begin
                    framed++;
                    if (pick < 20)
                    begin
                        rep.button_word = last_buttons;
                    end
                    else if (pick < 32)
                    begin
                        rep.button_word = last_buttons ^ (16'($urandom) & UNMAPPED_BITS);
                    end
                    else if (pick < 62)
                    begin
                        rep.button_word = last_buttons ^ (16'h1 << $urandom_range(15));
                    end
                    // Home would end the session, so it waits for the last test.
                    rep.button_word = rep.button_word & ~HOME_MASK;
                end
                send_report(rep);
            end
            wait_idle();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering reports that flip mapped bits other than home, so the block fills
    // up and has to stall its input.
    task automatic test_backpressure();
        logic [15:0] flips;
        begin
            src_idle_pct  = 0;
            sink_idle_pct = 0;
            hold_request  = 300;
            for (int i = 0; i < 16; i++)
            begin
                flips = 16'($urandom) & SAFE_MAPPED_BITS;
                if (flips == 16'h0000)
                begin
                    flips = 16'h0001;
                end
                send_good(last_buttons ^ flips);
            end
            wait_idle();
        end
    endtask

    // Home pressed ends the session: the run closes without sync and with
    // the stop mark, and from then on every report is ignored, a short read
    // and changing words among them.
    task automatic test_home_stop();
        begin
            src_idle_pct  = 20;
            sink_idle_pct = 20;
            send_good((last_buttons ^ 16'h0a03) | HOME_MASK);
            send_good(last_buttons ^ SAFE_MAPPED_BITS);
            send_report('{HEADER_OK, REPORT_OK, 16'h0000, 1'b1});
            send_good(16'h1234);
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------

    initial
    begin
        last_buttons       = 16'h0000;
        session_over       = 1'b0;
        hold_request       = 0;
        hold_left          = 0;
        cycle_count        = 0;
        fail_count         = 0;
        mismatch_count     = 0;
        reports_sent       = 0;
        events_seen        = 0;
        key_events         = 0;
        axis_events        = 0;
        sync_events        = 0;
        input_stall_cycles = 0;
        src_idle_pct       = 38;
        sink_idle_pct      = 84;

        rst_n              <= 1'b0;
        rpt_ch.valid       <= 1'b0;
        rpt_ch.header_byte <= 8'h00;
        rpt_ch.report_id   <= 8'h00;
        rpt_ch.button_word <= 16'h0000;
        rpt_ch.short_read  <= 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the first idling mix.
        test_framing();
        test_keys();
        test_axes();
        test_unmapped_bits();
        wait_idle();

        // Random part in three idling mixes.
        test_random_reports(50);
        src_idle_pct  = 84;
        sink_idle_pct = 38;
        test_random_reports(50);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_reports(50);

        test_backpressure();

        // Must come last: once home is pressed the block ignores everything.
        test_home_stop();

        if (pending_events.size() != 0)
        begin
            $display("ERROR: %0d expected events never arrived", pending_events.size());
            fail_count += pending_events.size();
        end

        $display("Summary: %0d reports sent, %0d events checked (%0d key, %0d axis, %0d sync).",
                 reports_sent, events_seen, key_events, axis_events, sync_events);
        $display("Summary: %0d cycles of input stall, %0d failures, session ended by home.",
                 input_stall_cycles, fail_count);

        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
